### src/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

    // Store geometry
    localparam int NUM_PAGES = 4096;
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = $clog2(NUM_WORDS);

    // Field and pointer widths
    localparam int PAGE_W    = 13;              // page pointer, holds NUM_PAGES
    localparam int START_W   = 12;
    localparam int CNT_W     = 13;
    localparam int SUM_W     = CNT_W + 1;
    localparam int WIDX_W    = PAGE_W - OFF_W;  // word index part of a pointer
    localparam int IDX_W     = OFF_W + 1;       // bit index, WORD_BITS means none

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic
    {
        STS_OK  = 1'b0,
        STS_OOM = 1'b1
    } status_t;

    typedef struct packed
    {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        word_t              wr_data;
    } mem_req_t;

    typedef struct packed
    {
        logic             cur_used;   // page at the scan point is used
        logic [IDX_W-1:0] next_idx;   // first bit that differs, WORD_BITS if none
    } seg_t;

    // Ones at bit positions off and above
    function automatic word_t mask_from(logic [OFF_W-1:0] off);
        word_t ones;
        ones = '1;
        return ones << off;
    endfunction

endpackage

### src/bpa_bitmap_mem.sv
`timescale 1ns / 1ps

module bpa_bitmap_mem
(
    input  logic              clk,
    input  logic              rst_n,
    input  bpa_pkg::mem_req_t req,
    output bpa_pkg::word_t    rd_data
);
    import bpa_pkg::*;

    word_t                mem [NUM_WORDS];
    word_t                rd_word_reg;
    logic [NUM_WORDS-1:0] valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem[req.rd_addr];
        end
    end

    // A word never written reads as all pages used
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '1;

endmodule

### src/bpa_run_finder.sv
`timescale 1ns / 1ps

module bpa_run_finder
(
    input  bpa_pkg::word_t                     word,
    input  logic [bpa_pkg::OFF_W-1:0]          off,
    input  logic [bpa_pkg::WIDX_W-1:0]         cur_widx,
    input  logic [bpa_pkg::PAGE_W-1:0]         hi,
    output bpa_pkg::seg_t                      seg
);
    import bpa_pkg::*;

    word_t used;
    word_t cand;

    // Pages at or past the search bound count as used
    assign used = word | ((hi[PAGE_W-1:OFF_W] == cur_widx) ? mask_from(hi[OFF_W-1:0]) : '0);
    assign cand = (used ^ {WORD_BITS{used[off]}}) & mask_from(off);

    always_comb
    begin
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                idx = IDX_W'(i);
            end
        end
        seg.cur_used = used[off];
        seg.next_idx = idx;
    end

endmodule

### src/bitmap_page_allocator_next_fit.sv
`timescale 1ns / 1ps

// Next-fit contiguous page allocator over a used/free page bitmap.
//
// Commands arrive on the s_* channel (tuser = cmd, tdata = page_count and
// start_page); one result per command leaves on the m_* channel (status,
// alloc_page, free_count). cfg_* writes page_limit, the upper search bound; it
// is always ready. The user writes it only while the block is idle; not enforced.
//
// The bitmap lives in a 64 x 64 synchronous memory. An allocate walks it from
// the rover: each word is read, then scanned one run of equal bits at a time,
// then the found run is marked word by word (read, write back). A free clears
// its run the same way, word by word. Commands are handled one at a time.
//
// Reset clears the per-word valid bits at once, so the whole map reads as used,
// the rover and the free count are zero and page_limit is 4096; no clearing
// pass is needed. A finished result waits in an output register, so a stalled
// receiver does not block the next command; a second result holds until the
// first transfer completes.

module bitmap_page_allocator_next_fit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] page_count, [24:13] start_page, rest zero
    input  logic [0:0]  s_tuser,   // [0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] status, [12:1] alloc_page, [25:13] free_count

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // page_limit
);
    import bpa_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_RESP
    } state_t;

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    limit_reg,  limit_next;
    logic [PAGE_W-1:0]   rover_reg,  rover_next;
    logic [PAGE_W-1:0]   total_reg,  total_next;
    logic [CNT_W-1:0]    n_reg,      n_next;
    logic [PAGE_W-1:0]   run_reg,    run_next;
    logic [PAGE_W-1:0]   pos_reg,    pos_next;
    logic [PAGE_W-1:0]   hi_reg,     hi_next;
    logic [PAGE_W-1:0]   end2_reg,   end2_next;
    logic                phase_reg,  phase_next;
    logic                mkval_reg,  mkval_next;
    status_t             res_sts_reg, res_sts_next;
    logic [START_W-1:0]  res_page_reg, res_page_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_sts_reg, out_sts_next;
    logic [START_W-1:0]  out_page_reg, out_page_next;
    logic [PAGE_W-1:0]   out_count_reg, out_count_next;

    mem_req_t            mem_req;
    word_t               rd_data;
    seg_t                seg;

    logic                in_xfer;
    cmd_t                in_cmd;
    logic [CNT_W-1:0]    in_count;
    logic [START_W-1:0]  in_start;

    logic [WIDX_W-1:0]   cur_widx;
    logic [OFF_W-1:0]    cur_off;
    logic [PAGE_W-1:0]   base_next;
    logic [PAGE_W-1:0]   lim;
    logic [PAGE_W-1:0]   end2;
    logic [SUM_W-1:0]    free_end;
    logic [PAGE_W-1:0]   free_end_clamp;
    logic [SUM_W-1:0]    free_sum;
    logic [IDX_W-1:0]    seg_len;
    logic [SUM_W-1:0]    run_sum;
    logic                word_end;
    logic [PAGE_W-1:0]   pos_after;
    logic [PAGE_W-1:0]   last_p1;
    logic [PAGE_W-1:0]   first_page;
    word_t               mark_mask;

    assign in_xfer  = s_tvalid && s_tready;
    assign in_cmd   = cmd_t'(s_tuser[0]);
    assign in_count = s_tdata[CNT_W-1:0];
    assign in_start = s_tdata[CNT_W +: START_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(32 - 1 - START_W - PAGE_W){1'b0}}, out_count_reg, out_page_reg,
                        out_sts_reg};

    // Position of the scan or mark pointer
    assign cur_widx  = pos_reg[PAGE_W-1:OFF_W];
    assign cur_off   = pos_reg[OFF_W-1:0];
    assign base_next = {cur_widx + WIDX_W'(1), {OFF_W{1'b0}}};

    // Clamp the limit to the store; second search ends at min(rover, limit)
    assign lim  = (limit_reg > CNT_W'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES) : limit_reg;
    assign end2 = (rover_reg < lim) ? rover_reg : lim;

    assign free_end       = SUM_W'(in_start) + SUM_W'(in_count);
    assign free_end_clamp = (free_end > SUM_W'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES)
                                                           : free_end[PAGE_W-1:0];
    assign free_sum       = SUM_W'(total_reg) + SUM_W'(in_count);

    // Scan step arithmetic
    assign seg_len   = seg.next_idx - {1'b0, cur_off};
    assign run_sum   = SUM_W'(run_reg) + SUM_W'(seg_len);
    assign word_end  = (seg.next_idx == IDX_W'(WORD_BITS));
    assign pos_after = word_end ? base_next : {cur_widx, seg.next_idx[OFF_W-1:0]};
    assign last_p1   = PAGE_W'(SUM_W'(pos_reg) + SUM_W'(n_reg) - SUM_W'(run_reg));
    assign first_page = last_p1 - n_reg;

    // Bits of the current word inside [pos, hi)
    assign mark_mask = mask_from(cur_off) &
                       ((hi_reg[PAGE_W-1:OFF_W] == cur_widx) ? ~mask_from(hi_reg[OFF_W-1:0])
                                                             : '1);

    always_comb
    begin
        mem_req         = '0;
        mem_req.rd_addr = cur_widx[WADDR_W-1:0];
        mem_req.wr_addr = cur_widx[WADDR_W-1:0];
        mem_req.wr_data = mkval_reg ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
        mem_req.rd_en   = (state_reg == S_SCAN_RD) || (state_reg == S_MARK_RD);
        mem_req.wr_en   = (state_reg == S_MARK_WR);
    end

    bpa_bitmap_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    bpa_run_finder u_finder
    (
        .word     (rd_data),
        .off      (cur_off),
        .cur_widx (cur_widx),
        .hi       (hi_reg),
        .seg      (seg)
    );

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        rover_next     = rover_reg;
        total_next     = total_reg;
        n_next         = n_reg;
        run_next       = run_reg;
        pos_next       = pos_reg;
        hi_next        = hi_reg;
        end2_next      = end2_reg;
        phase_next     = phase_reg;
        mkval_next     = mkval_reg;
        res_sts_next   = res_sts_reg;
        res_page_next  = res_page_reg;
        out_sts_next   = out_sts_reg;
        out_page_next  = out_page_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next        = in_count;
                    run_next      = '0;
                    res_sts_next  = STS_OK;
                    res_page_next = '0;
                    if (in_cmd == CMD_FREE)
                    begin
                        // Clear [start, end); the count saturates at the store size
                        pos_next   = {1'b0, in_start};
                        hi_next    = free_end_clamp;
                        mkval_next = 1'b0;
                        total_next = (free_sum > SUM_W'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES)
                                                                    : free_sum[PAGE_W-1:0];
                        state_next = ({1'b0, in_start} < free_end_clamp) ? S_MARK_RD : S_RESP;
                    end
                    else
                    begin
                        end2_next = end2;
                        if (in_count == '0)
                        begin
                            res_sts_next = STS_OOM;
                            state_next   = S_RESP;
                        end
                        else if (rover_reg < lim)
                        begin
                            pos_next   = rover_reg;
                            hi_next    = lim;
                            phase_next = 1'b0;
                            state_next = S_SCAN_RD;
                        end
                        else if (end2 != '0)
                        begin
                            pos_next   = '0;
                            hi_next    = end2;
                            phase_next = 1'b1;
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            res_sts_next = STS_OOM;
                            state_next   = S_RESP;
                        end
                    end
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (!seg.cur_used && (run_sum >= SUM_W'(n_reg)))
                begin
                    // Run complete: claim it and move the rover past it
                    rover_next    = last_p1;
                    total_next    = (total_reg > n_reg) ? total_reg - n_reg : '0;
                    res_page_next = first_page[START_W-1:0];
                    pos_next      = first_page;
                    hi_next       = last_p1;
                    mkval_next    = 1'b1;
                    state_next    = S_MARK_RD;
                end
                else
                begin
                    run_next = seg.cur_used ? '0 : run_sum[PAGE_W-1:0];
                    pos_next = pos_after;
                    if (!word_end)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (pos_after < hi_reg)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (!phase_reg && (end2_reg != '0))
                    begin
                        // Wrap to the second search from page zero
                        phase_next = 1'b1;
                        pos_next   = '0;
                        hi_next    = end2_reg;
                        run_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        res_sts_next = STS_OOM;
                        state_next   = S_RESP;
                    end
                end
            end

            S_MARK_RD:
            begin
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                pos_next   = base_next;
                state_next = (base_next >= hi_reg) ? S_RESP : S_MARK_RD;
            end

            S_RESP:
            begin
                // Hold while an earlier result still waits for its transfer
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_sts_next   = res_sts_reg;
                    out_page_next  = res_page_reg;
                    out_count_next = total_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= CNT_W'(NUM_PAGES);
            rover_reg     <= '0;
            total_reg     <= '0;
            n_reg         <= '0;
            run_reg       <= '0;
            pos_reg       <= '0;
            hi_reg        <= '0;
            end2_reg      <= '0;
            phase_reg     <= 1'b0;
            mkval_reg     <= 1'b0;
            res_sts_reg   <= STS_OK;
            res_page_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_sts_reg   <= STS_OK;
            out_page_reg  <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            rover_reg     <= rover_next;
            total_reg     <= total_next;
            n_reg         <= n_next;
            run_reg       <= run_next;
            pos_reg       <= pos_next;
            hi_reg        <= hi_next;
            end2_reg      <= end2_next;
            phase_reg     <= phase_next;
            mkval_reg     <= mkval_next;
            res_sts_reg   <= res_sts_next;
            res_page_reg  <= res_page_next;
            out_valid_reg <= out_valid_next;
            out_sts_reg   <= out_sts_next;
            out_page_reg  <= out_page_next;
            out_count_reg <= out_count_next;
        end
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= PAGE_W'(NUM_PAGES))
        else $error("free count above store size");

    a_rover_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rover_reg <= PAGE_W'(NUM_PAGES))
        else $error("rover past store");

    a_run_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (run_reg < n_reg))
        else $error("scan run reached request without completing");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (pos_reg < hi_reg))
        else $error("bitmap write outside mark range");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("command taken while busy");

endmodule

### dv/bitmap_page_allocator_next_fit_tb.sv
`timescale 1ns / 1ps

module bitmap_page_allocator_next_fit_tb;

    import bpa_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 11;
    localparam int CYCLE_LIMIT = 20_000_000;  // a full-miss scan per item, stalls included
    localparam int SETTLE_CYC  = 64;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_PHASES  = 8;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idling_t;

    // One result transfer as the block should present it
    typedef struct
    {
        status_t           status;
        logic [START_W-1:0] page;
        logic [CNT_W-1:0]   free_count;
    } outcome_t;

    // A run handed out by the block, kept so that it can be given back later
    typedef struct
    {
        int first;
        int count;
    } run_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [12:0] page_count, [24:13] start_page, rest zero
    logic [0:0]  s_tuser   = '0;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [0] status, [12:1] alloc_page, [25:13] free_count
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data  = '0;   // page_limit

    // Shadow of the allocator state
    bit page_used [NUM_PAGES];
    int roving_page;
    int spare_pages;
    int page_limit_cfg;

    outcome_t pending_outcomes[$];
    run_t     live_runs[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    bitmap_page_allocator_next_fit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Randomly withhold tready on the result side
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Shadow allocator
    // ------------------------------------------------------------------

    // Look for n free pages in [lo, hi); claim them and move the rover past them
    function automatic bit claim_run(int n, int lo, int hi, output int first);
        int run;
        int p;
        int q;
        run   = 0;
        first = 0;
        for (p = lo; p < hi; p++)
        begin
            if (page_used[p])
                run = 0;
            else
            begin
                run++;
                if (run == n)
                begin
                    first = p + 1 - n;
                    for (q = first; q <= p; q++)
                        page_used[q] = 1'b1;
                    roving_page = p + 1;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic outcome_t next_fit_outcome(cmd_t cmd, int count, int start);
        outcome_t o;
        int       lim;
        int       scan_end;
        int       where;
        int       p;
        bit       found;
        o.status = STS_OK;
        o.page   = '0;
        if (cmd == CMD_ALLOC)
        begin
            lim      = (page_limit_cfg > NUM_PAGES) ? NUM_PAGES : page_limit_cfg;
            // The wrap-around pass stops at the rover, so runs across it are missed
            scan_end = (roving_page < lim) ? roving_page : lim;
            found    = 1'b0;
            where    = 0;
            if (count != 0)
            begin
                found = claim_run(count, roving_page, lim, where);
                if (!found)
                    found = claim_run(count, 0, scan_end, where);
            end
            if (found)
            begin
                o.page      = where[START_W-1:0];
                spare_pages = (spare_pages > count) ? spare_pages - count : 0;
            end
            else
                o.status = STS_OOM;
        end
        else
        begin
            // Pages past the store are dropped, but the full count still adds up
            for (p = start; p < start + count && p < NUM_PAGES; p++)
                page_used[p] = 1'b0;
            spare_pages = spare_pages + count;
            if (spare_pages > NUM_PAGES)
                spare_pages = NUM_PAGES;
        end
        o.free_count = spare_pages[CNT_W-1:0];
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void report_mismatch(string what, int want, int got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // Compare every result transfer with the oldest outstanding command
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result, tdata", 0, m_tdata);
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_tdata[0] !== want.status)
                    report_mismatch("status", want.status, m_tdata[0]);
                if (m_tdata[12:1] !== want.page)
                    report_mismatch("alloc_page", want.page, m_tdata[12:1]);
                if (m_tdata[25:13] !== want.free_count)
                    report_mismatch("free_count", want.free_count, m_tdata[25:13]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Hold off at random, present one command and predict its result on transfer
    task automatic send_command(cmd_t cmd, int count, int start);
        outcome_t o;
        run_t     r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, start[START_W-1:0], count[CNT_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        o = next_fit_outcome(cmd, count, start);
        pending_outcomes.push_back(o);
        if (cmd == CMD_ALLOC && o.status == STS_OK)
        begin
            r.first = o.page;
            r.count = count;
            live_runs.push_back(r);
        end
    endtask

    // Drop tvalid and wait for every outstanding result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_page_limit(int value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[12:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        page_limit_cfg = value;
    endtask

    task automatic set_idling(idling_t mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 78 :
                         (mode == IDLE_RECEIVER) ? 0  :
                         (mode == IDLE_BOTH)     ? 31 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 78 :
                         (mode == IDLE_BOTH)     ? 31 : 0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every page is used after reset, and a zero-length request never succeeds
    task automatic test_empty_map();
        send_command(CMD_ALLOC, 1, 0);
        send_command(CMD_ALLOC, 0, 4095);
    endtask

    task automatic test_alloc_and_free();
        send_command(CMD_FREE, 64, 0);
        send_command(CMD_ALLOC, 10, 4095);      // start_page is ignored on allocate
        send_command(CMD_ALLOC, 1, 0);
        send_command(CMD_FREE, 4096, 4095);     // runs past the store, count saturates
        send_command(CMD_FREE, 8, 20);          // already free
        send_command(CMD_FREE, 0, 100);
        send_command(CMD_ALLOC, 4096, 0);       // most of the map is still used
    endtask

    task automatic test_search_bounds();
        send_command(CMD_FREE, 4096, 0);
        send_command(CMD_ALLOC, 4096, 0);       // the whole map would cover the rover
        send_command(CMD_ALLOC, 4085, 0);       // fill up to the limit
        send_command(CMD_ALLOC, 5, 0);          // rover at the limit: wrap to page 0
        write_page_limit(2);
        send_command(CMD_ALLOC, 1, 0);          // rover past the limit, low pages used
        send_command(CMD_FREE, 2, 0);
        send_command(CMD_ALLOC, 1, 0);
        write_page_limit(0);
        send_command(CMD_ALLOC, 1, 0);          // nothing below a zero limit
        write_page_limit(NUM_PAGES);
    endtask

    task automatic random_command();
        int   pick;
        int   sel;
        int   count;
        run_t r;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            sel = $urandom_range(99);
            if (sel < 2)
                count = 0;
            else if (sel < 5)
                count = $urandom_range(1024, NUM_PAGES);
            else if (sel < 15)
                count = $urandom_range(17, 512);
            else
                count = $urandom_range(1, 16);
            send_command(CMD_ALLOC, count, $urandom_range(4095));
        end
        else if (pick < 85 && live_runs.size() != 0)
        begin
            // Give back a run that the block handed out
            sel = $urandom_range(live_runs.size() - 1);
            r   = live_runs[sel];
            live_runs.delete(sel);
            send_command(CMD_FREE, r.count, r.first);
        end
        else
        begin
            count = ($urandom_range(99) < 5) ? $urandom_range(NUM_PAGES) : $urandom_range(64);
            send_command(CMD_FREE, count, $urandom_range(4095));
        end
    endtask

    // Phases of random traffic, each under its own limit and idling pattern
    task automatic test_random_traffic();
        int limits [NUM_PHASES];
        int counts [NUM_PHASES];
        int ph;
        int i;
        limits = '{NUM_PAGES, $urandom_range(1, 4095), 1, 4095, 2048, 0,
                   $urandom_range(1, 4095), NUM_PAGES};
        counts = '{260, 220, 80, 220, 220, 50, 220, 280};
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_page_limit(limits[ph]);
            set_idling(idling_t'(ph % 4));
            for (i = 0; i < counts[ph]; i++)
                random_command();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        foreach (page_used[p])
            page_used[p] = 1'b1;
        roving_page    = 0;
        spare_pages    = 0;
        page_limit_cfg = NUM_PAGES;

        // Hold reset, then release it on a clock edge
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(IDLE_NONE);
        test_empty_map();
        test_alloc_and_free();
        test_search_bounds();
        test_random_traffic();

        wait_drained();
        // Watch for stray results before calling it
        repeat (SETTLE_CYC) @(posedge clk);

        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
